### rtl/core/bma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bma_pkg
// shared types, constants and helpers of the buddy memory allocator
// ----------------------------------------------------------------------------
package bma_pkg;

	localparam int TOTAL_UNITS_DEF = 1024;
	localparam int OWNER_BITS_DEF  = 16;
	localparam int PID_W           = 16;
	localparam int REQ_W           = 11;
	localparam int GRANT_W         = 11;
	localparam int CFG_W           = 4;
	localparam int NEED_W          = 5;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic             op;
		logic [PID_W-1:0] process_id;
		logic [REQ_W-1:0] request_size;
	} bma_in_t;

	typedef struct packed {
		logic [GRANT_W-1:0] granted_size;
		logic               release_ok;
	} bma_out_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLR_STEP,
		CMD_LOAD,
		CMD_READ,
		CMD_SCAN_A,
		CMD_SCAN_R,
		CMD_SPLIT,
		CMD_ALLOC_FIN,
		CMD_MERGE_RD,
		CMD_MERGE_EVAL,
		CMD_REL_FIN,
		CMD_OUT
	} bma_cmd_t;

	typedef struct packed {
		logic bad;
		logic scan_end;
		logic hit;
		logic split_more;
		logic found;
		logic merge_can;
		logic merge_ok;
		logic clear_last;
		logic is_release;
	} bma_stat_t;

	// smallest n with 2^n >= req
	function automatic logic [NEED_W-1:0] need_order(input logic [REQ_W-1:0] req);
		logic [NEED_W-1:0] n;
		n = '0;
		for (int i = 0; i <= REQ_W; i++) begin
			if (((REQ_W+1)'(1) << i) < (REQ_W+1)'(req)) begin
				n = NEED_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

### rtl/core/bma_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bma_ctrl
// sequencer: clearing pass, descriptor scans, split and merge steps, result
// ----------------------------------------------------------------------------
module bma_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                req_valid,
	output logic                     req_stall,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	input  wire bma_pkg::bma_stat_t  stat,
	output bma_pkg::bma_cmd_t        cmd
);
	import bma_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_EVAL,
		ST_SPLIT,
		ST_MERGE,
		ST_MEVAL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = CMD_NONE;
		unique case (state_q)
			ST_CLEAR: cmd = CMD_CLR_STEP;
			ST_IDLE: begin
				if (req_valid) cmd = CMD_LOAD;
			end
			ST_CHECK: begin
				if (!stat.bad) cmd = CMD_READ;
			end
			ST_EVAL: cmd = stat.is_release ? CMD_SCAN_R : CMD_SCAN_A;
			ST_SPLIT: begin
				if (stat.found) cmd = stat.split_more ? CMD_SPLIT : CMD_ALLOC_FIN;
			end
			ST_MERGE: cmd = stat.merge_can ? CMD_MERGE_RD : CMD_REL_FIN;
			ST_MEVAL: cmd = stat.merge_ok ? CMD_MERGE_EVAL : CMD_REL_FIN;
			ST_DONE: begin
				if (out_free) cmd = CMD_OUT;
			end
			default: cmd = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!rsp_stall) rsp_valid_q <= 1'b0;
			if (cfg_we) begin
				// new pool size drops every block, restart the clearing pass
				state_q <= ST_CLEAR;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						if (stat.clear_last) state_q <= ST_IDLE;
					end
					ST_IDLE: begin
						if (req_valid) state_q <= ST_CHECK;
					end
					ST_CHECK: state_q <= stat.bad ? ST_DONE : ST_EVAL;
					ST_EVAL: begin
						if (stat.is_release) begin
							if (stat.hit) state_q <= ST_MERGE;
							else if (stat.scan_end) state_q <= ST_DONE;
						end else if (stat.scan_end) begin
							state_q <= ST_SPLIT;
						end
					end
					ST_SPLIT: begin
						if (!stat.found || !stat.split_more) state_q <= ST_DONE;
					end
					ST_MERGE: state_q <= stat.merge_can ? ST_MEVAL : ST_DONE;
					ST_MEVAL: state_q <= stat.merge_ok ? ST_MERGE : ST_DONE;
					ST_DONE: begin
						if (out_free) begin
							rsp_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/bma_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bma_dpath
// descriptor memory, scan pointer, best-fit and merge registers, result
// ----------------------------------------------------------------------------
module bma_dpath #(
	parameter int TOTAL_UNITS = bma_pkg::TOTAL_UNITS_DEF,
	parameter int OWNER_BITS  = bma_pkg::OWNER_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [bma_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire bma_pkg::bma_in_t             req_data,
	output bma_pkg::bma_out_t                 rsp_data,
	input  wire bma_pkg::bma_cmd_t            cmd,
	output bma_pkg::bma_stat_t                stat
);
	import bma_pkg::*;

	localparam int AW      = $clog2(TOTAL_UNITS);
	localparam int PW      = AW + 1;
	localparam int MAX_ORD = $clog2(TOTAL_UNITS + 1) - 1;
	localparam int ORD_W   = $clog2(MAX_ORD + 1);
	localparam int CMPW    = (ORD_W > NEED_W) ? ORD_W : NEED_W;

	typedef struct packed {
		logic                  head;
		logic [ORD_W-1:0]      order;
		logic                  used;
		logic [OWNER_BITS-1:0] owner;
	} ent_t;

	ent_t mem [TOTAL_UNITS];
	ent_t rdata_q;

	logic [ORD_W-1:0]      pool_order_q;
	logic [PW-1:0]         addr_q;
	logic                  op_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [NEED_W-1:0]     need_q;
	logic                  req_zero_q;
	logic                  found_q;
	logic                  ok_q;
	logic [AW-1:0]         best_q;
	logic [ORD_W-1:0]      best_ord_q;
	bma_out_t              rsp_q;

	logic [PW-1:0]    pool;
	logic [PW-1:0]    next_addr;
	logic [AW-1:0]    bud;
	logic [AW-1:0]    merge_lo;
	logic [AW-1:0]    merge_hi;
	logic [CMPW-1:0]  need_c;
	logic             fit;
	logic             we;
	logic [AW-1:0]    wa;
	ent_t             wd;
	logic [AW-1:0]    rd_addr;
	logic [ORD_W-1:0] cfg_ord;
	bma_out_t         result;

	assign pool      = PW'(1) << pool_order_q;
	// blocks tile the pool, so the next head sits one block size further on
	assign next_addr = addr_q + (PW'(1) << rdata_q.order);
	assign bud       = best_q ^ (AW'(1) << best_ord_q);
	assign merge_lo  = (bud < best_q) ? bud : best_q;
	assign merge_hi  = (bud < best_q) ? best_q : bud;
	assign need_c    = CMPW'(need_q);
	assign cfg_ord   = (32'(cfg_wdata) > MAX_ORD) ? ORD_W'(MAX_ORD) : ORD_W'(cfg_wdata);
	assign fit       = !rdata_q.used && (CMPW'(rdata_q.order) >= need_c) &&
	                   (!found_q || (rdata_q.order < best_ord_q));

	always_comb begin
		stat.bad        = (op_q == OP_ALLOC) && (req_zero_q || (need_c > CMPW'(pool_order_q)));
		stat.scan_end   = (next_addr >= pool);
		stat.hit        = rdata_q.used && (rdata_q.owner == owner_q);
		stat.split_more = (CMPW'(best_ord_q) > need_c);
		stat.found      = found_q;
		stat.merge_can  = (best_ord_q < pool_order_q);
		stat.merge_ok   = rdata_q.head && !rdata_q.used && (rdata_q.order == best_ord_q);
		stat.clear_last = (addr_q == PW'(TOTAL_UNITS - 1));
		stat.is_release = (op_q == OP_RELEASE);
	end

	always_comb begin
		result.granted_size = ((op_q == OP_ALLOC) && ok_q) ?
		                      GRANT_W'((GRANT_W+1)'(1) << need_q) : '0;
		result.release_ok   = (op_q == OP_RELEASE) && ok_q;
	end

	always_comb begin
		we      = 1'b0;
		wa      = addr_q[AW-1:0];
		wd      = '0;
		rd_addr = addr_q[AW-1:0];
		case (cmd)
			CMD_CLR_STEP: begin
				we = 1'b1;
				if (addr_q == '0) begin
					wd.head  = 1'b1;
					wd.order = pool_order_q;
				end
			end
			CMD_READ: rd_addr = addr_q[AW-1:0];
			CMD_SCAN_A, CMD_SCAN_R: rd_addr = next_addr[AW-1:0];
			CMD_SPLIT: begin
				we       = 1'b1;
				wa       = best_q + (AW'(1) << (best_ord_q - ORD_W'(1)));
				wd.head  = 1'b1;
				wd.order = best_ord_q - ORD_W'(1);
			end
			CMD_ALLOC_FIN: begin
				we       = 1'b1;
				wa       = best_q;
				wd.head  = 1'b1;
				wd.order = ORD_W'(need_q);
				wd.used  = 1'b1;
				wd.owner = owner_q;
			end
			CMD_MERGE_RD: rd_addr = bud;
			CMD_MERGE_EVAL: begin
				// upper half loses its head, lower half is written at the end
				we = 1'b1;
				wa = merge_hi;
			end
			CMD_REL_FIN: begin
				we       = 1'b1;
				wa       = best_q;
				wd.head  = 1'b1;
				wd.order = best_ord_q;
				wd.owner = owner_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_order_q <= '0;
			addr_q       <= '0;
		end else if (cfg_we) begin
			pool_order_q <= cfg_ord;
			addr_q       <= '0;
		end else begin
			case (cmd)
				CMD_CLR_STEP: addr_q <= addr_q + PW'(1);
				CMD_LOAD: addr_q <= '0;
				CMD_SCAN_A, CMD_SCAN_R: addr_q <= next_addr;
				default: addr_q <= addr_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q       <= req_data.op;
				owner_q    <= OWNER_BITS'(req_data.process_id);
				need_q     <= need_order(req_data.request_size);
				req_zero_q <= (req_data.request_size == '0);
				found_q    <= 1'b0;
				ok_q       <= 1'b0;
			end
			CMD_SCAN_A: begin
				if (fit) begin
					found_q    <= 1'b1;
					best_q     <= addr_q[AW-1:0];
					best_ord_q <= rdata_q.order;
				end
			end
			CMD_SCAN_R: begin
				if (stat.hit) begin
					best_q     <= addr_q[AW-1:0];
					best_ord_q <= rdata_q.order;
				end
			end
			CMD_SPLIT: best_ord_q <= best_ord_q - ORD_W'(1);
			CMD_MERGE_EVAL: begin
				best_q     <= merge_lo;
				best_ord_q <= best_ord_q + ORD_W'(1);
			end
			CMD_ALLOC_FIN, CMD_REL_FIN: ok_q <= 1'b1;
			CMD_OUT: rsp_q <= result;
			default: ok_q <= ok_q;
		endcase
	end

	assign rsp_data = rsp_q;

endmodule
`default_nettype wire

### rtl/core/buddy_memory_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_memory_allocator
// buddy allocator over a pool of 2^pool_size_log2 units
// ----------------------------------------------------------------------------
// request channel: req_valid/req_stall/req_data carry allocate or release
// transactions; a transaction is taken when req_valid is high and req_stall
// low. response channel: rsp_valid/rsp_stall/rsp_data return one result per
// request, in order. one request is in work at a time; the next one can be taken
// at the earliest in the same cycle as the response of the previous one appears.
// an allocate walks every block descriptor (blocks are walked head to head, at
// most the pool size of them), then splits the best fit block once per level;
// a release walks up to the owner's block, then merges one level at a time,
// each level with a read and an evaluation step, until a buddy is not free,
// and answers after the whole walk when the owner holds no block. a bad
// request size answers right after the check.
// after reset and after every cfg_we write the descriptor memory is cleared,
// one entry per cycle, over all TOTAL_UNITS entries; requests are stalled then.
// a stalled response holds in the output register; the block still accepts
// the next request and finishes it, then waits with it until the output
// register frees up.
// ----------------------------------------------------------------------------
module buddy_memory_allocator #(
	parameter int TOTAL_UNITS = bma_pkg::TOTAL_UNITS_DEF,
	parameter int OWNER_BITS  = bma_pkg::OWNER_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [bma_pkg::CFG_W-1:0] cfg_wdata,
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire bma_pkg::bma_in_t          req_data,
	output logic                           rsp_valid,
	input  wire logic                      rsp_stall,
	output bma_pkg::bma_out_t              rsp_data
);
	import bma_pkg::*;

	bma_cmd_t  cmd;
	bma_stat_t stat;

	bma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bma_dpath #(
		.TOTAL_UNITS (TOTAL_UNITS),
		.OWNER_BITS  (OWNER_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_data  (req_data),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
`default_nettype wire
